// File: src/apq_pkg.sv
// Shared types and codes for the array priority queue.
// Opcodes, result status codes, controller states and the command/status
// bundles between the controller and the datapath. No dependencies.
package apq_pkg;

  localparam int ELEM_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 4;
  localparam int TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch the request
    logic scan_init;   // rewind read pointer for the max search
    logic shift_init;  // point read pointer just past the found entry
    logic rd_issue;    // read entry at the read pointer
    logic scan_cmp;    // compare returning read data against the best
    logic shift_wr;    // write returning read data one place down
    logic ins;         // append the request and bump the fill count
    logic fill_dec;    // drop one entry from the fill count
    logic res_load;    // load the output register
  } apq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            rp_done;   // read pointer reached the fill count
    logic            dv;        // read data returning this cycle
    logic            out_free;  // output register can take a result
  } apq_stat_t;

endpackage

// File: src/apq_ctrl.sv
// Sequencing state machine for the array priority queue.
// Drives apq_cmd_t into the datapath and watches apq_stat_t; uses apq_pkg.
module apq_ctrl
  import apq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_valid,
  output logic      s_ready,
  input  apq_stat_t stat,
  output apq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if ((stat.op == OP_PEEK || stat.op == OP_DELETE) && !stat.empty) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.rd_issue = !stat.rp_done;
        cmd.scan_cmp = 1'b1;
        if (stat.rp_done && !stat.dv) begin
          if (stat.op == OP_DELETE) begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.rd_issue = !stat.rp_done;
        cmd.shift_wr = 1'b1;
        if (stat.rp_done && !stat.dv) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the previous result has been taken
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.ins      = (stat.op == OP_INSERT) && !stat.full;
          cmd.fill_dec = (stat.op == OP_DELETE) && !stat.empty;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded while output register busy");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.rp_done && !stat.dv && stat.op == OP_DELETE) |=>
      state == S_SHIFT)
    else $error("delete did not enter shift phase");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DECODE)
    else $error("accepted item not decoded");

endmodule

// File: src/apq_dp.sv
// Datapath of the array priority queue: entry memories, fill count, read
// pointer, running maximum and output register. Uses apq_pkg.
module apq_dp
  import apq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  apq_cmd_t            cmd,
  output apq_stat_t           stat,
  input  logic [OP_W-1:0]     req_op,
  input  logic [ELEM_W-1:0]   req_elem,
  input  logic [PRIO_W-1:0]   req_prio,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [STAT_W-1:0]   out_status,
  output logic [ELEM_W-1:0]   out_elem,
  output logic [PRIO_W-1:0]   out_prio,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ELEM_W-1:0] elem_mem [CAPACITY];
  logic [PRIO_W-1:0] prio_mem [CAPACITY];

  logic [OP_W-1:0]   op_q;
  logic [ELEM_W-1:0] elem_q;
  logic [PRIO_W-1:0] prio_q;

  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;
  logic [CW-1:0]     rp;
  logic              dv;
  logic [AW-1:0]     rd_addr_q;
  logic [ELEM_W-1:0] rd_elem;
  logic [PRIO_W-1:0] rd_prio;

  logic [AW-1:0]     best_idx;
  logic [ELEM_W-1:0] best_elem;
  logic [PRIO_W-1:0] best_prio;

  logic              full;
  logic              empty;
  logic              is_take;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [ELEM_W-1:0] wr_elem;
  logic [PRIO_W-1:0] wr_prio;
  status_t           res_status;

  assign full    = (fill == CW'(CAPACITY));
  assign empty   = (fill == '0);
  assign is_take = (op_q == OP_PEEK) || (op_q == OP_DELETE);

  assign stat.op       = op_q;
  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.rp_done  = (rp == fill);
  assign stat.dv       = dv;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= req_op;
      elem_q <= req_elem;
      prio_q <= req_prio;
    end
  end

  always_comb begin
    fill_next = fill;
    if (cmd.ins) begin
      fill_next = fill + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_next = fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      dv   <= 1'b0;
    end else begin
      fill <= fill_next;
      dv   <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      rp <= '0;
    end else if (cmd.shift_init) begin
      rp <= CW'(best_idx) + CW'(1);
    end else if (cmd.rd_issue) begin
      rp <= rp + CW'(1);
    end
  end

  // Write port: append on insert, move one place down while shifting.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_elem = elem_q;
    wr_prio = prio_q;
    if (cmd.ins) begin
      mem_we = 1'b1;
    end else if (cmd.shift_wr && dv) begin
      mem_we  = 1'b1;
      wr_addr = rd_addr_q - AW'(1);
      wr_elem = rd_elem;
      wr_prio = rd_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[wr_addr] <= wr_elem;
      prio_mem[wr_addr] <= wr_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_elem   <= elem_mem[rp[AW-1:0]];
      rd_prio   <= prio_mem[rp[AW-1:0]];
      rd_addr_q <= rp[AW-1:0];
    end
  end

  // Strict compare keeps the earliest entry on ties.
  always_ff @(posedge clk) begin
    if (cmd.scan_cmp && dv) begin
      if (rd_addr_q == '0 || rd_prio > best_prio) begin
        best_idx  <= rd_addr_q;
        best_elem <= rd_elem;
        best_prio <= rd_prio;
      end
    end
  end

  always_comb begin
    res_status = ST_OK;
    if (op_q == OP_INSERT && full) begin
      res_status = ST_FULL;
    end else if (is_take && empty) begin
      res_status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= res_status;
      out_elem   <= (op_q == OP_DELETE && !empty) ? best_elem : '0;
      out_prio   <= (is_take && !empty) ? best_prio : '0;
      out_count  <= COUNT_W'(fill_next);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_wr && dv) |-> (rd_addr_q != '0 && CW'(rd_addr_q) < fill))
    else $error("shift write outside held entries");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins || cmd.fill_dec) |=> $stable(fill))
    else $error("fill count changed without a command");

endmodule

// File: src/array_priority_queue.sv
// Array priority queue: unsorted array held in arrival order, served by
// priority. Insert, and peek or delete on an empty queue, skip the search;
// peek runs a max search over the N entries held and delete adds a shift of
// the later entries, both through the single read port that they share. One
// item at a time: the next item is taken as its result shows. Synchronous
// reset empties the queue.
module array_priority_queue
  import apq_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [1:0] opcode, [33:2] element_value, [49:34] priority_req, [55:50] zero
  input  logic [TDATA_W-1:0] s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [1:0] status, [33:2] element_out, [49:34] priority_out, [53:50] count,
  // [55:54] zero
  output logic [TDATA_W-1:0] m_axis_tdata
);

  apq_cmd_t            cmd;
  apq_stat_t           stat;
  logic [STAT_W-1:0]   out_status;
  logic [ELEM_W-1:0]   out_elem;
  logic [PRIO_W-1:0]   out_prio;
  logic [COUNT_W-1:0]  out_count;

  apq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  apq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_op     (s_axis_tdata[1:0]),
    .req_elem   (s_axis_tdata[33:2]),
    .req_prio   (s_axis_tdata[49:34]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_elem   (out_elem),
    .out_prio   (out_prio),
    .out_count  (out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_prio, out_elem, out_status};

endmodule
